// ===== rtl/skbt_pkg.sv =====
`default_nettype none

package skbt_pkg;

  // Fixed widths of the channel fields.
  localparam int FRAME_W   = 16;
  localparam int SLOT_W    = 6;
  localparam int CNT_OUT_W = 7;

  // Defaults for the storage parameters of the top level.
  localparam int DEF_TABLE_DEPTH = 64;
  localparam int DEF_FRAME_BITS  = 16;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_QUERY  = 1'b1
  } op_t;

  typedef struct packed {
    logic               operation;
    logic [FRAME_W-1:0] frame;
  } in_word_t;

  typedef struct packed {
    logic [SLOT_W-1:0]    slot_index;
    logic                 already_present;
    logic                 table_full;
    logic                 pre_valid;
    logic [SLOT_W-1:0]    pre_index;
    logic [FRAME_W-1:0]   pre_frame;
    logic                 post_valid;
    logic [SLOT_W-1:0]    post_index;
    logic [FRAME_W-1:0]   post_frame;
    logic [CNT_OUT_W-1:0] entry_count;
  } out_word_t;

  // Summary flags from the bracket encoder.
  typedef struct packed {
    logic found;
    logic pre_valid;
    logic post_valid;
  } res_flags_t;

endpackage

`default_nettype wire

// ===== rtl/skbt_cell.sv =====
`default_nettype none

module skbt_cell #(
  parameter int KEY_W = skbt_pkg::DEF_FRAME_BITS
) (
  input  wire logic             clk,
  input  wire logic             cmp_en,
  input  wire logic [KEY_W-1:0] cmp_key,
  input  wire logic             valid,
  input  wire logic             ins_en,
  input  wire logic [KEY_W-1:0] ins_key,
  input  wire logic [KEY_W-1:0] left_key,
  input  wire logic             left_above,
  output logic      [KEY_W-1:0] key_r,
  output logic                  above_r,
  output logic                  eq_r
);

  import skbt_pkg::*;

  logic [KEY_W-1:0] key_nxt;

  // An empty cell counts as above every frame, so the flags across the row
  // form a thermometer whose edge is the insertion point.
  always_comb begin
    key_nxt = key_r;
    if (ins_en && above_r) begin
      key_nxt = left_above ? left_key : ins_key;
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
    if (cmp_en) begin
      above_r <= !valid || (key_r > cmp_key);
      eq_r    <= valid && (key_r == cmp_key);
    end
  end

endmodule

`default_nettype wire

// ===== rtl/skbt_resolve.sv =====
`default_nettype none

module skbt_resolve #(
  parameter int DEPTH = skbt_pkg::DEF_TABLE_DEPTH,
  parameter int KEY_W = skbt_pkg::DEF_FRAME_BITS,
  localparam int LE_W = $clog2(DEPTH + 1)
) (
  input  wire logic [DEPTH-1:0] above,
  input  wire logic [DEPTH-1:0] eq,
  input  wire logic [DEPTH-1:0] valid,
  input  wire logic [KEY_W-1:0] keys [DEPTH],
  output logic      [LE_W-1:0]  le,
  output logic      [KEY_W-1:0] pre_key,
  output logic      [KEY_W-1:0] post_key,
  output skbt_pkg::res_flags_t  flags
);

  import skbt_pkg::*;

  logic [DEPTH-1:0] first_above;
  logic [DEPTH-1:0] last_below;

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      first_above[i] = above[i] && ((i == 0) || !above[(i == 0) ? 0 : i - 1]);
      last_below[i]  = !above[i] &&
                       ((i == DEPTH - 1) || above[(i == DEPTH - 1) ? i : i + 1]);
    end
  end

  // The edge is one-hot, so the index and both keys are plain OR reductions.
  always_comb begin
    le       = '0;
    pre_key  = '0;
    post_key = '0;
    if (!above[DEPTH-1]) begin
      le = LE_W'(DEPTH);
    end
    for (int i = 0; i < DEPTH; i++) begin
      if (first_above[i]) begin
        le = le | LE_W'(i);
      end
      if (first_above[i] && valid[i]) begin
        post_key = post_key | keys[i];
      end
      if (last_below[i]) begin
        pre_key = pre_key | keys[i];
      end
    end
    flags.found      = |eq;
    flags.pre_valid  = !above[0];
    flags.post_valid = |(first_above & valid);
  end

endmodule

`default_nettype wire

// ===== rtl/sorted_keyframe_bracket_table.sv =====
`default_nettype none

// Sorted keyframe bracket table.
// Keeps up to TABLE_DEPTH unique frame numbers in ascending order in a row
// of cells, one key per cell. Words arrive on in_valid/in_ready: operation
// 0 inserts the frame unless it is stored already or the table is full;
// operation 1 asks for the bracketing pair (last key at or below the frame,
// first key above it). Every input word yields exactly one result word on
// out_valid/out_ready. On acceptance every cell compares its key with the
// frame into its flags; in S_RES the encoder turns them into an index and
// keys, registered once the result register is free, and an insert shifts
// the upper cells one place right in the same edge. in_ready is high only
// while the block waits for a word, so none is taken before the last
// result is registered. The result register holds the word while the
// receiver stalls; a new word may be accepted meanwhile, but its result
// waits until the held one is taken. Synchronous reset empties the table
// (count zero); key contents are not cleared and are never read unwritten.
module sorted_keyframe_bracket_table #(
  parameter int TABLE_DEPTH = skbt_pkg::DEF_TABLE_DEPTH,
  parameter int FRAME_BITS  = skbt_pkg::DEF_FRAME_BITS
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire skbt_pkg::in_word_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output skbt_pkg::out_word_t      out_data
);

  import skbt_pkg::*;

  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_RES  = 2'b10
  } state_t;

  state_t                state_r, state_nxt;
  logic [CNT_W-1:0]      count_r, count_nxt;
  logic                  op_r;
  logic [FRAME_BITS-1:0] frame_r;
  logic                  out_valid_r, out_valid_nxt;
  out_word_t             out_data_r, out_data_nxt;

  logic                  accept;
  logic                  load;
  logic                  full;
  logic                  do_insert;
  logic [FRAME_BITS-1:0] in_key;

  logic [TABLE_DEPTH-1:0] cell_valid;
  logic [TABLE_DEPTH-1:0] cell_above;
  logic [TABLE_DEPTH-1:0] cell_eq;
  logic [FRAME_BITS-1:0]  cell_key [TABLE_DEPTH];

  logic [CNT_W-1:0]      le;
  logic [FRAME_BITS-1:0] pre_key;
  logic [FRAME_BITS-1:0] post_key;
  res_flags_t            flags;

  assign in_ready  = (state_r == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign load      = (state_r == S_RES) && (!out_valid_r || out_ready);
  assign full      = (count_r == CNT_W'(TABLE_DEPTH));
  assign do_insert = load && (op_r == OP_INSERT) && !flags.found && !full;
  assign in_key    = FRAME_BITS'(in_data.frame);

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    assign cell_valid[i] = (CNT_W'(i) < count_r);

    if (i == 0) begin : g_head
      skbt_cell #(.KEY_W(FRAME_BITS)) u_cell (
        .clk        (clk),
        .cmp_en     (accept),
        .cmp_key    (in_key),
        .valid      (cell_valid[i]),
        .ins_en     (do_insert),
        .ins_key    (frame_r),
        .left_key   (frame_r),
        .left_above (1'b0),
        .key_r      (cell_key[i]),
        .above_r    (cell_above[i]),
        .eq_r       (cell_eq[i])
      );
    end else begin : g_body
      skbt_cell #(.KEY_W(FRAME_BITS)) u_cell (
        .clk        (clk),
        .cmp_en     (accept),
        .cmp_key    (in_key),
        .valid      (cell_valid[i]),
        .ins_en     (do_insert),
        .ins_key    (frame_r),
        .left_key   (cell_key[i-1]),
        .left_above (cell_above[i-1]),
        .key_r      (cell_key[i]),
        .above_r    (cell_above[i]),
        .eq_r       (cell_eq[i])
      );
    end
  end

  skbt_resolve #(
    .DEPTH (TABLE_DEPTH),
    .KEY_W (FRAME_BITS)
  ) u_resolve (
    .above    (cell_above),
    .eq       (cell_eq),
    .valid    (cell_valid),
    .keys     (cell_key),
    .le       (le),
    .pre_key  (pre_key),
    .post_key (post_key),
    .flags    (flags)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_RES;
        end
      end
      S_RES: begin
        if (load) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign count_nxt = do_insert ? count_r + CNT_W'(1) : count_r;

  always_comb begin
    out_data_nxt             = '0;
    out_data_nxt.entry_count = CNT_OUT_W'(count_nxt);
    if (op_r == OP_INSERT) begin
      if (flags.found) begin
        out_data_nxt.slot_index      = SLOT_W'(le - CNT_W'(1));
        out_data_nxt.already_present = 1'b1;
      end else if (full) begin
        out_data_nxt.table_full = 1'b1;
      end else begin
        out_data_nxt.slot_index = SLOT_W'(le);
      end
    end else begin
      if (flags.pre_valid) begin
        out_data_nxt.pre_valid = 1'b1;
        out_data_nxt.pre_index = SLOT_W'(le - CNT_W'(1));
        out_data_nxt.pre_frame = FRAME_W'(pre_key);
      end
      if (flags.post_valid) begin
        out_data_nxt.post_valid = 1'b1;
        out_data_nxt.post_index = SLOT_W'(le);
        out_data_nxt.post_frame = FRAME_W'(post_key);
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r    <= in_data.operation;
      frame_r <= in_key;
    end
    if (load) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(TABLE_DEPTH))
    else $error("entry count exceeds table depth");

  a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
    do_insert |=> count_r == $past(count_r) + CNT_W'(1))
    else $error("new key stored without count increment");

  a_bracket_order: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RES && op_r == OP_QUERY && flags.pre_valid && flags.post_valid)
      |-> pre_key < post_key)
    else $error("bracket keys out of order");

  a_found_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RES && flags.found) |-> flags.pre_valid)
    else $error("matching key without a predecessor edge");
`endif

endmodule

`default_nettype wire
